[rtl/cmhp_pkg.sv]
// ----------------------------------------------------------------------------
// cmhp_pkg
// Shared widths, types, matrix coefficients and register codes for the
// hue-preserving 3x3 color correction matrix.
// ----------------------------------------------------------------------------
package cmhp_pkg;

   localparam int COEF_FRAC_BITS = 14;
   localparam int LANES          = 3;

   localparam int COMP_W  = 16;
   localparam int OUT_W   = 17;
   localparam int COEF_W  = COEF_FRAC_BITS + 3;
   localparam int PROD_W  = COEF_W + COMP_W + 1;
   localparam int SUM_W   = COMP_W + 4;
   localparam int MAG_W   = SUM_W;
   localparam int FS_W    = 16;
   localparam int DVD_W   = MAG_W + FS_W;
   localparam int QUO_W   = OUT_W;

   // one stage loads the partial remainder, one per quotient bit after it
   localparam int DIV_STAGES = QUO_W + 1;

   localparam int ST_PROD     = 0;
   localparam int ST_SUM      = 1;
   localparam int ST_MAX      = 2;
   localparam int ST_DVD      = 3;
   localparam int ST_DIV      = 4;
   localparam int ST_OUT      = ST_DIV + DIV_STAGES;
   localparam int PIPE_STAGES = ST_OUT + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAT_THRESHOLD,
      CSR_FULL_SCALE
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] SAT_THRESHOLD_RESET = 16'd65525;
   localparam logic [CSR_DATA_W-1:0] FULL_SCALE_RESET    = 16'd65535;

   typedef logic        [COMP_W-1:0] comp_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic        [MAG_W-1:0]  mag_type;
   typedef logic        [FS_W-1:0]   fs_type;
   typedef logic        [DVD_W-1:0]  dvd_type;
   typedef logic        [QUO_W-1:0]  quo_type;
   typedef logic signed [OUT_W-1:0]  out_type;

   localparam out_type OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam out_type OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // largest quotient magnitudes that still fit the output field
   localparam quo_type NEG_LIMIT = QUO_W'(1) << (OUT_W - 1);
   localparam quo_type POS_LIMIT = NEG_LIMIT - QUO_W'(1);

   typedef struct packed {
      logic                         use_div;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0][OUT_W-1:0]  direct;
   } side_type;

   typedef struct packed {
      logic    ovf;
      quo_type quo;
   } div_result_type;

   // nominal value in millionths to fixed point, halves away from zero
   function automatic coef_type fixed_coef(input longint micro);
      longint mag;
      longint q;
      mag = (micro < 0) ? -micro : micro;
      q   = (mag * (longint'(1) <<< COEF_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
      if (micro < 0) begin
         q = -q;
      end
      return COEF_W'(q);
   endfunction

   // row-major, row = output component, column = input component
   localparam coef_type COEF [LANES*LANES] = '{
      fixed_coef(1901824), fixed_coef(-972035), fixed_coef(70211),
      fixed_coef(-229410), fixed_coef(1659384), fixed_coef(-429974),
      fixed_coef(42001),   fixed_coef(-519143), fixed_coef(1477141)
   };

   localparam prod_type TRUNC_BIAS = (prod_type'(1) <<< COEF_FRAC_BITS) - prod_type'(1);

endpackage

[rtl/cmhp_if.sv]
// ----------------------------------------------------------------------------
// cmhp_req_if / cmhp_rsp_if
// Valid/ready channels for camera pixels in and converted pixels out.
// ----------------------------------------------------------------------------
interface cmhp_req_if;
   logic               valid;
   logic               ready;
   cmhp_pkg::comp_type in_red;
   cmhp_pkg::comp_type in_green;
   cmhp_pkg::comp_type in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   output ready);
endinterface

interface cmhp_rsp_if;
   logic              valid;
   logic              ready;
   cmhp_pkg::out_type out_red;
   cmhp_pkg::out_type out_green;
   cmhp_pkg::out_type out_blue;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   output ready);
endinterface

[rtl/cmhp_div.sv]
// ----------------------------------------------------------------------------
// cmhp_div
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage. Flags quotients that do not fit QUO_W bits.
// ----------------------------------------------------------------------------
module cmhp_div (
   input  logic                                   clock,
   input  logic [cmhp_pkg::DIV_STAGES-1:0]        load,
   input  cmhp_pkg::dvd_type                      dvd [cmhp_pkg::LANES],
   input  cmhp_pkg::mag_type                      dvr,
   output cmhp_pkg::div_result_type               result [cmhp_pkg::LANES]
);

   cmhp_pkg::mag_type rem_ff  [cmhp_pkg::QUO_W][cmhp_pkg::LANES];
   cmhp_pkg::mag_type rem_in  [cmhp_pkg::QUO_W][cmhp_pkg::LANES];
   cmhp_pkg::quo_type low_ff  [cmhp_pkg::QUO_W][cmhp_pkg::LANES];
   cmhp_pkg::quo_type low_in  [cmhp_pkg::QUO_W][cmhp_pkg::LANES];
   cmhp_pkg::mag_type dvr_ff  [cmhp_pkg::QUO_W];
   cmhp_pkg::mag_type dvr_in  [cmhp_pkg::QUO_W];
   cmhp_pkg::quo_type quo_ff  [cmhp_pkg::DIV_STAGES][cmhp_pkg::LANES];
   cmhp_pkg::quo_type quo_in  [cmhp_pkg::DIV_STAGES][cmhp_pkg::LANES];
   logic              ovf_ff  [cmhp_pkg::DIV_STAGES][cmhp_pkg::LANES];
   logic              ovf_in  [cmhp_pkg::DIV_STAGES][cmhp_pkg::LANES];

   always_comb begin
      logic [cmhp_pkg::MAG_W:0] trial;
      logic                     ge;
      for (int l = 0; l < cmhp_pkg::LANES; l++) begin
         // upper bits at or above the divisor mean the quotient overflows
         rem_in[0][l] = cmhp_pkg::MAG_W'(dvd[l][cmhp_pkg::DVD_W-1:cmhp_pkg::QUO_W]);
         ovf_in[0][l] = cmhp_pkg::MAG_W'(dvd[l][cmhp_pkg::DVD_W-1:cmhp_pkg::QUO_W]) >= dvr;
         low_in[0][l] = dvd[l][cmhp_pkg::QUO_W-1:0];
         quo_in[0][l] = '0;
      end
      dvr_in[0] = dvr;
      for (int k = 1; k < cmhp_pkg::DIV_STAGES; k++) begin
         for (int l = 0; l < cmhp_pkg::LANES; l++) begin
            trial = {rem_ff[k-1][l], low_ff[k-1][l][cmhp_pkg::QUO_W-1]};
            ge    = trial >= {1'b0, dvr_ff[k-1]};
            quo_in[k][l] = {quo_ff[k-1][l][cmhp_pkg::QUO_W-2:0], ge};
            ovf_in[k][l] = ovf_ff[k-1][l];
            if (k < cmhp_pkg::QUO_W) begin
               rem_in[k][l] = ge ? cmhp_pkg::MAG_W'(trial - {1'b0, dvr_ff[k-1]})
                                 : trial[cmhp_pkg::MAG_W-1:0];
               low_in[k][l] = low_ff[k-1][l] << 1;
            end
         end
         if (k < cmhp_pkg::QUO_W) begin
            dvr_in[k] = dvr_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < cmhp_pkg::DIV_STAGES; k++) begin
         if (load[k]) begin
            quo_ff[k] <= quo_in[k];
            ovf_ff[k] <= ovf_in[k];
            if (k < cmhp_pkg::QUO_W) begin
               rem_ff[k] <= rem_in[k];
               low_ff[k] <= low_in[k];
               dvr_ff[k] <= dvr_in[k];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < cmhp_pkg::LANES; l++) begin
         result[l].ovf = ovf_ff[cmhp_pkg::DIV_STAGES-1][l];
         result[l].quo = quo_ff[cmhp_pkg::DIV_STAGES-1][l];
      end
   end

endmodule

[rtl/color_matrix_hue_preserving.sv]
// Latency: a pixel transferred in passes 23 register stages, output register
//   included, before it shows as a valid result.
// Throughput: one pixel per clock unless a low rsp_if.ready stalls a full
//   pipeline; the 18-stage restoring divider that does the overflow rescale
//   loads in its first stage, then one quotient bit in each of the 17 after it.
// Reset: synchronous, clears all stage valid bits and loads the threshold
//   and full-scale registers with their defaults; payload is not reset.
// ----------------------------------------------------------------------------
// color_matrix_hue_preserving
// Hue-preserving 3x3 color correction matrix: saturation check, Q2.14
// matrix multiply, overflow rescale by full_scale / max.
// ----------------------------------------------------------------------------
module color_matrix_hue_preserving (
   input  logic                                  clock,
   input  logic                                  reset,
   cmhp_req_if.sink                              req_if,
   cmhp_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [cmhp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cmhp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers
   cmhp_pkg::comp_type thr_ff;
   cmhp_pkg::fs_type   fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cmhp_pkg::SAT_THRESHOLD_RESET;
         fs_ff  <= cmhp_pkg::FULL_SCALE_RESET;
      end else if (csr_we) begin
         unique case (cmhp_pkg::csr_index_type'(csr_index))
            cmhp_pkg::CSR_SAT_THRESHOLD: begin
               thr_ff <= csr_wdata;
            end
            cmhp_pkg::CSR_FULL_SCALE: begin
               fs_ff <= csr_wdata;
            end
         endcase
      end
   end

   // stage handshake: a stage takes new data when it is empty or moves on
   logic [cmhp_pkg::PIPE_STAGES-1:0] v_ff;
   logic [cmhp_pkg::PIPE_STAGES-1:0] vin;
   logic [cmhp_pkg::PIPE_STAGES-1:0] rdy;
   logic [cmhp_pkg::PIPE_STAGES-1:0] load;

   always_comb begin
      for (int k = 0; k < cmhp_pkg::PIPE_STAGES; k++) begin
         rdy[k]  = rsp_if.ready | (|((~v_ff) >> k));
         vin[k]  = (k == 0) ? req_if.valid : v_ff[(k == 0) ? 0 : k-1];
         load[k] = vin[k] & rdy[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < cmhp_pkg::PIPE_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= vin[k];
            end
         end
      end
   end

   // no transfer is taken while reset is held
   assign req_if.ready = rdy[0] & ~reset;
   assign rsp_if.valid = v_ff[cmhp_pkg::PIPE_STAGES-1];

   function automatic cmhp_pkg::out_type clamp_out(input cmhp_pkg::sum_type v);
      cmhp_pkg::out_type r;
      if (v < cmhp_pkg::SUM_W'(cmhp_pkg::OUT_MIN)) begin
         r = cmhp_pkg::OUT_MIN;
      end else if (v > cmhp_pkg::SUM_W'(cmhp_pkg::OUT_MAX)) begin
         r = cmhp_pkg::OUT_MAX;
      end else begin
         r = cmhp_pkg::OUT_W'(v);
      end
      return r;
   endfunction

   // products and saturation test
   cmhp_pkg::prod_type prod_ff [cmhp_pkg::LANES][cmhp_pkg::LANES];
   cmhp_pkg::prod_type prod_in [cmhp_pkg::LANES][cmhp_pkg::LANES];
   logic               sat0_ff, sat0_in;

   // truncated row sums
   cmhp_pkg::sum_type  sum_ff [cmhp_pkg::LANES];
   cmhp_pkg::sum_type  sum_in [cmhp_pkg::LANES];
   logic               sat1_ff;

   // maximum and overflow test
   cmhp_pkg::sum_type  res_ff [cmhp_pkg::LANES];
   cmhp_pkg::mag_type  mx_ff, mx_in;
   logic               sat2_ff;
   logic               scale_ff, scale_in;

   // dividends and results that bypass the divider
   cmhp_pkg::dvd_type  dvd_ff [cmhp_pkg::LANES];
   cmhp_pkg::dvd_type  dvd_in [cmhp_pkg::LANES];
   cmhp_pkg::mag_type  dvr_ff;
   cmhp_pkg::side_type side3_ff, side3_in;

   // side data riding along with the divider stages
   cmhp_pkg::side_type side_ff [cmhp_pkg::DIV_STAGES];

   cmhp_pkg::div_result_type div_result [cmhp_pkg::LANES];

   cmhp_pkg::out_type  out_ff [cmhp_pkg::LANES];
   cmhp_pkg::out_type  out_in [cmhp_pkg::LANES];

   always_comb begin
      cmhp_pkg::comp_type comp [cmhp_pkg::LANES];
      cmhp_pkg::prod_type p;
      cmhp_pkg::sum_type  acc;
      cmhp_pkg::sum_type  mx;
      cmhp_pkg::quo_type  q;
      cmhp_pkg::side_type side;

      comp[0] = req_if.in_red;
      comp[1] = req_if.in_green;
      comp[2] = req_if.in_blue;
      sat0_in = 1'b0;
      for (int j = 0; j < cmhp_pkg::LANES; j++) begin
         if (comp[j] > thr_ff) begin
            sat0_in = 1'b1;
         end
      end
      for (int i = 0; i < cmhp_pkg::LANES; i++) begin
         for (int j = 0; j < cmhp_pkg::LANES; j++) begin
            prod_in[i][j] = cmhp_pkg::PROD_W'(cmhp_pkg::COEF[i*cmhp_pkg::LANES + j])
                          * cmhp_pkg::PROD_W'($signed({1'b0, comp[j]}));
         end
      end

      // drop fraction bits toward zero, then sum exactly
      for (int i = 0; i < cmhp_pkg::LANES; i++) begin
         acc = '0;
         for (int j = 0; j < cmhp_pkg::LANES; j++) begin
            p = prod_ff[i][j] + (prod_ff[i][j][cmhp_pkg::PROD_W-1] ? cmhp_pkg::TRUNC_BIAS
                                                                   : cmhp_pkg::prod_type'(0));
            p = p >>> cmhp_pkg::COEF_FRAC_BITS;
            acc = acc + cmhp_pkg::SUM_W'(p);
         end
         sum_in[i] = acc;
      end

      mx = sum_ff[0];
      if (sum_ff[1] > mx) begin
         mx = sum_ff[1];
      end
      if (sum_ff[2] > mx) begin
         mx = sum_ff[2];
      end
      mx_in    = cmhp_pkg::MAG_W'(mx);
      scale_in = !sat1_ff && (mx > $signed(cmhp_pkg::SUM_W'(thr_ff)));

      // rescale works on magnitudes, the sign is put back at the end
      side3_in.use_div = scale_ff;
      for (int l = 0; l < cmhp_pkg::LANES; l++) begin
         side3_in.neg[l] = res_ff[l][cmhp_pkg::SUM_W-1];
         dvd_in[l] = cmhp_pkg::DVD_W'($unsigned(res_ff[l][cmhp_pkg::SUM_W-1]
                                                ? cmhp_pkg::MAG_W'(-res_ff[l])
                                                : cmhp_pkg::MAG_W'(res_ff[l])))
                   * cmhp_pkg::DVD_W'(fs_ff);
         side3_in.direct[l] = sat2_ff ? cmhp_pkg::OUT_W'({1'b0, fs_ff})
                                      : clamp_out(res_ff[l]);
      end

      side = side_ff[cmhp_pkg::DIV_STAGES-1];
      for (int l = 0; l < cmhp_pkg::LANES; l++) begin
         q = div_result[l].quo;
         if (!side.use_div) begin
            out_in[l] = side.direct[l];
         end else if (side.neg[l]) begin
            out_in[l] = (div_result[l].ovf || q > cmhp_pkg::NEG_LIMIT)
                        ? cmhp_pkg::OUT_MIN : cmhp_pkg::OUT_W'(-q);
         end else begin
            out_in[l] = (div_result[l].ovf || q > cmhp_pkg::POS_LIMIT)
                        ? cmhp_pkg::OUT_MAX : cmhp_pkg::OUT_W'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[cmhp_pkg::ST_PROD]) begin
         prod_ff <= prod_in;
         sat0_ff <= sat0_in;
      end
      if (load[cmhp_pkg::ST_SUM]) begin
         sum_ff  <= sum_in;
         sat1_ff <= sat0_ff;
      end
      if (load[cmhp_pkg::ST_MAX]) begin
         res_ff   <= sum_ff;
         mx_ff    <= mx_in;
         sat2_ff  <= sat1_ff;
         scale_ff <= scale_in;
      end
      if (load[cmhp_pkg::ST_DVD]) begin
         dvd_ff   <= dvd_in;
         dvr_ff   <= mx_ff;
         side3_ff <= side3_in;
      end
      for (int k = 0; k < cmhp_pkg::DIV_STAGES; k++) begin
         if (load[cmhp_pkg::ST_DIV + k]) begin
            side_ff[k] <= (k == 0) ? side3_ff : side_ff[(k == 0) ? 0 : k-1];
         end
      end
      if (load[cmhp_pkg::ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   cmhp_div u_div (
      .clock  (clock),
      .load   (load[cmhp_pkg::ST_DIV +: cmhp_pkg::DIV_STAGES]),
      .dvd    (dvd_ff),
      .dvr    (dvr_ff),
      .result (div_result)
   );

   assign rsp_if.out_red   = out_ff[0];
   assign rsp_if.out_green = out_ff[1];
   assign rsp_if.out_blue  = out_ff[2];

endmodule
